/* design/bffs_pkg.sv */
// ----------------------------------------------------------------------------
// bffs_pkg: shared types and constants of the bracket frame field splitter
// Character codes, scan event struct and defaults used across the block.
// ----------------------------------------------------------------------------
package bffs_pkg;

  localparam int unsigned MaxFieldsDefault = 8;
  localparam logic [7:0]  MinLenReset      = 8'd4;

  localparam logic [7:0] ChSqOpen  = 8'h5B;  // '['
  localparam logic [7:0] ChSqClose = 8'h5D;  // ']'
  localparam logic [7:0] ChPOpen   = 8'h28;  // '('
  localparam logic [7:0] ChPClose  = 8'h29;  // ')'
  localparam logic [7:0] ChSemi    = 8'h3B;  // ';'

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindSq    = 2'd1;
  localparam logic [1:0] KindParen = 2'd2;

  // table entry: length in the upper byte, start in the lower byte
  localparam int unsigned EntryW = 16;

  typedef struct packed {
    logic fail;   // single kind-0 result
    logic burst;  // frame closed with kept fields
    logic paren;  // closer was ')'
  } scan_evt_t;

  function automatic logic is_alnum(input logic [7:0] b);
    is_alnum = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39);
  endfunction

endpackage

/* design/bracket_frame_field_splitter.sv */
// ----------------------------------------------------------------------------
// bracket_frame_field_splitter: bracket frame field splitter, top level
// Scanner, field table RAM and result readout with an output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one buffer byte per transaction in tdata; tlast marks the
//   final byte of the buffer. m_axis returns field results: tuser is the
//   frame kind, tlast marks the last result of a burst.
//   cfg_wr_en_i / cfg_wr_data_i set the minimum kept field length (reset 4);
//   write it only while the block is idle.
//   Throughput: one byte per cycle while no result is pending. A failure
//   result is loaded in the accepting cycle and shows in the cycle after.
//   A closing bracket with N kept fields starts a readout burst of one table
//   read and one output load per field, in turn, since the field table has a
//   single read port; s_axis_tready stays low during the burst.
//   The output register lets a byte be accepted while a result waits, as
//   long as the result is taken in the same cycle or the register is free.
//   If m_axis_tready is low the burst and the input both stall; nothing is
//   lost. Reset clears scan state and the output valid; the table needs no
//   clearing since entries are read only after being written.
// ----------------------------------------------------------------------------
module bracket_frame_field_splitter #(
  parameter int unsigned MaxFields = bffs_pkg::MaxFieldsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,   // min_field_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [3:0] field_count, [6:4] field_number,
                                       // [14:7] field_start, [22:15] field_length
  output logic [1:0]  m_axis_tuser,    // [1:0] frame_kind
  output logic        m_axis_tlast     // last_of_run
);
  import bffs_pkg::*;

  localparam int unsigned IdxW = (MaxFields > 1) ? $clog2(MaxFields) : 1;
  localparam int unsigned CntW = $clog2(MaxFields + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        min_len_q;
  logic              acc;
  logic              out_free;
  logic              tbl_we;
  logic [IdxW-1:0]   tbl_waddr;
  logic [EntryW-1:0] tbl_wdata;
  logic [EntryW-1:0] tbl_rdata;
  scan_evt_t         evt;
  logic [CntW-1:0]   cnt;
  logic [CntW-1:0]   bcnt_q, bcnt_d;
  logic              bparen_q, bparen_d;
  logic [IdxW-1:0]   ridx_q, ridx_d;
  logic              rd_last;

  logic              ov_q, ov_d;
  logic              load;
  logic [1:0]        kind_d, kind_q;
  logic [3:0]        fcnt_d, fcnt_q;
  logic [2:0]        fnum_d, fnum_q;
  logic [7:0]        fstart_d, fstart_q;
  logic [7:0]        flen_d, flen_q;
  logic              last_d, last_q;

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  bffs_scan #(.MaxFields(MaxFields)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .byte_i     (s_axis_tdata),
    .eob_i      (s_axis_tlast),
    .min_len_i  (min_len_q),
    .tbl_we_o   (tbl_we),
    .tbl_waddr_o(tbl_waddr),
    .tbl_wdata_o(tbl_wdata),
    .evt_o      (evt),
    .cnt_o      (cnt)
  );

  bffs_ram #(.Width(EntryW), .Depth(MaxFields)) u_tbl (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .re_i   (state_q == ST_READ),
    .raddr_i(ridx_q),
    .rdata_o(tbl_rdata)
  );

  assign rd_last = ((CntW+1)'(ridx_q) + 1'b1) == (CntW+1)'(bcnt_q);

  always_comb begin
    state_d  = state_q;
    bcnt_d   = bcnt_q;
    bparen_d = bparen_q;
    ridx_d   = ridx_q;
    load     = 1'b0;
    kind_d   = KindNone;
    fcnt_d   = 4'd0;
    fnum_d   = 3'd0;
    fstart_d = 8'd0;
    flen_d   = 8'd0;
    last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (evt.fail) begin
          load = 1'b1;
        end else if (evt.burst) begin
          bcnt_d   = cnt;
          bparen_d = evt.paren;
          ridx_d   = '0;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_free) begin
          load     = 1'b1;
          kind_d   = bparen_q ? KindParen : KindSq;
          fcnt_d   = 4'(bcnt_q);
          fnum_d   = 3'(ridx_q);
          fstart_d = tbl_rdata[7:0];
          flen_d   = tbl_rdata[15:8];
          last_d   = rd_last;
          if (rd_last) begin
            state_d = ST_IDLE;
          end else begin
            ridx_d  = ridx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    ov_d = load ? 1'b1 : (ov_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ov_q      <= 1'b0;
      min_len_q <= MinLenReset;
      bcnt_q    <= '0;
      bparen_q  <= 1'b0;
      ridx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ov_q     <= ov_d;
      bcnt_q   <= bcnt_d;
      bparen_q <= bparen_d;
      ridx_q   <= ridx_d;
      if (cfg_wr_en_i) begin
        min_len_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      fcnt_q   <= fcnt_d;
      fnum_q   <= fnum_d;
      fstart_q <= fstart_d;
      flen_q   <= flen_d;
      last_q   <= last_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {1'b0, flen_q, fstart_q, fnum_q, fcnt_q};

endmodule

/* design/bffs_ram.sv */
// ----------------------------------------------------------------------------
// bffs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bffs_ram #(
  parameter  int unsigned Width = 16,
  parameter  int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bffs_scan.sv */
// ----------------------------------------------------------------------------
// bffs_scan: frame scanner
// Tracks position, frame phase and the open field; writes kept fields to
// the field table and flags failure or burst events per byte.
// ----------------------------------------------------------------------------
module bffs_scan #(
  parameter  int unsigned MaxFields = bffs_pkg::MaxFieldsDefault,
  localparam int unsigned IdxW      = (MaxFields > 1) ? $clog2(MaxFields) : 1,
  localparam int unsigned CntW      = $clog2(MaxFields + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [7:0]           byte_i,
  input  logic                 eob_i,
  input  logic [7:0]           min_len_i,
  output logic                 tbl_we_o,
  output logic [IdxW-1:0]      tbl_waddr_o,
  output logic [bffs_pkg::EntryW-1:0] tbl_wdata_o,
  output bffs_pkg::scan_evt_t  evt_o,
  output logic [CntW-1:0]      cnt_o
);
  import bffs_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'b001,
    PH_FRAME = 3'b010,
    PH_DONE  = 3'b100
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            paren_q, paren_d;
  logic [7:0]      pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic            valid_q, valid_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic [7:0]      start_q, start_d;

  logic            keep;
  logic [CntW-1:0] kept_inc;
  logic [7:0]      closer;
  logic [7:0]      pos_nx;

  assign pos_nx   = pos_q + 8'd1;
  assign kept_inc = kept_q + 1'b1;
  assign closer   = paren_q ? ChPClose : ChSqClose;
  assign keep     = valid_q && (len_q >= min_len_i) &&
                    (kept_q < CntW'(MaxFields));

  assign tbl_waddr_o = kept_q[IdxW-1:0];
  assign tbl_wdata_o = {len_q, start_q};

  always_comb begin
    phase_d  = phase_q;
    paren_d  = paren_q;
    pos_d    = pos_nx;
    len_d    = len_q;
    valid_d  = valid_q;
    kept_d   = kept_q;
    start_d  = start_q;
    tbl_we_o = 1'b0;
    evt_o    = '0;
    evt_o.paren = paren_q;
    cnt_o    = kept_q;

    case (phase_q)
      PH_WAIT: begin
        if (byte_i == ChSqOpen || byte_i == ChPOpen) begin
          paren_d = (byte_i == ChPOpen);
          start_d = pos_nx;
          len_d   = 8'd0;
          valid_d = 1'b1;
          kept_d  = '0;
          phase_d = PH_FRAME;
        end
      end
      PH_FRAME: begin
        if (byte_i == ChSemi) begin
          if (keep) begin
            tbl_we_o = 1'b1;
            kept_d   = kept_inc;
            if (kept_inc == CntW'(MaxFields)) begin
              evt_o.fail = 1'b1;
              phase_d    = PH_DONE;
            end
          end
          start_d = pos_nx;
          len_d   = 8'd0;
          valid_d = 1'b1;
        end else if (byte_i == closer) begin
          if (keep) begin
            tbl_we_o = 1'b1;
            kept_d   = kept_inc;
          end
          cnt_o       = kept_d;
          evt_o.fail  = (kept_d == '0);
          evt_o.burst = (kept_d != '0);
          phase_d     = PH_DONE;
        end else if (is_alnum(byte_i)) begin
          if (len_q != 8'hFF) begin
            len_d = len_q + 8'd1;
          end
        end else begin
          valid_d = 1'b0;
        end
      end
      default: ;  // done: ignore bytes until end of buffer
    endcase

    if (eob_i) begin
      // open or unstarted frame at end of buffer fails
      if (phase_d == PH_WAIT || phase_d == PH_FRAME) begin
        evt_o.fail = 1'b1;
      end
      phase_d = PH_WAIT;
      paren_d = 1'b0;
      pos_d   = 8'd0;
      len_d   = 8'd0;
      valid_d = 1'b1;
      kept_d  = '0;
      start_d = 8'd0;
    end

    if (!acc_i) begin
      tbl_we_o = 1'b0;
      evt_o.fail  = 1'b0;
      evt_o.burst = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      paren_q <= 1'b0;
      pos_q   <= 8'd0;
      len_q   <= 8'd0;
      valid_q <= 1'b1;
      kept_q  <= '0;
      start_q <= 8'd0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      paren_q <= paren_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      valid_q <= valid_d;
      kept_q  <= kept_d;
      start_q <= start_d;
    end
  end

endmodule
